[rtl/core/tcap_pkg.sv]
// Shared types, register indexes and constants for the traction current autopilot.
// No dependencies; every other file in rtl/core refers to this package by scoped names.
package tcap_pkg;

  // Work queue between the front and the back
  localparam int unsigned QueueDepth = 2;

  // Configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] RegCurrentMax  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegSpeedGain   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegSlipGain    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegRegenDis    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegLevelScale  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegHoldoffTick = 3'd5;

  // Register reset values
  localparam logic [14:0] CurrentMaxRst   = 15'd8000;
  localparam logic [15:0] SpeedGainRst    = 16'd4096;
  localparam logic [15:0] SlipGainRst     = 16'd4096;
  localparam logic        RegenDisRst     = 1'b0;
  localparam logic [15:0] LevelScaleRst   = 16'd32768;
  localparam logic [15:0] HoldoffTicksRst = 16'd10;

  // Control constants: 40 kPa lock threshold, 5 A relay band, 5 km/h hysteresis
  localparam logic [9:0]         PressureLimit = 10'd40;
  localparam logic signed [15:0] RelayBand     = 16'sd50;
  localparam logic signed [12:0] LockErrBand   = 13'sd50;
  localparam logic [15:0]        CountMax      = 16'hFFFF;

  // Drive mode codes (2-bit signed)
  localparam logic signed [1:0] ModeBrake    = -2'sd1;
  localparam logic signed [1:0] ModeNeutral  = 2'sd0;
  localparam logic signed [1:0] ModeTraction = 2'sd1;

  typedef struct packed {
    logic [11:0] speed_target;
    logic [11:0] speed_train;
    logic [11:0] speed_wheel;
    logic [9:0]  cylinder_pressure;
    logic        motion_allowed;
    logic        handle_at_zero;
    logic        traction_active;
    logic        braking_active;
  } in_item_t;

  typedef struct packed {
    logic signed [1:0]  drive_mode;
    logic signed [15:0] drive_level;
    logic               traction_locked;
    logic               holdoff_busy;
  } out_item_t;

  typedef struct packed {
    logic [14:0] current_max;
    logic [15:0] speed_gain;
    logic [15:0] slip_gain;
    logic        regen_disable;
    logic [15:0] level_scale;
    logic [15:0] holdoff_ticks;
  } cfg_t;

  // Classified tick as it travels from the front to the back
  typedef struct packed {
    logic signed [12:0] err;
    logic [11:0]        slip;
    logic               lock_set;
    logic               err_small;
    logic               motion;
    logic               at_zero;
    logic               trac_on;
    logic               brake_on;
  } work_t;

endpackage

[rtl/core/tcap_in_if.sv]
// Input channel of the traction current autopilot: valid/ready plus one control tick.
// Depends on tcap_pkg for the payload type.
interface tcap_in_if;
  logic                valid;
  logic                ready;
  tcap_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/tcap_out_if.sv]
// Output channel of the traction current autopilot: valid/ready plus one result.
// Depends on tcap_pkg for the payload type.
interface tcap_out_if;
  logic                valid;
  logic                ready;
  tcap_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/traction_current_autopilot_core.sv]
// Top level of the traction current autopilot: configuration registers, front, queue, back.
// Depends on tcap_pkg, tcap_in_if, tcap_out_if, tcap_front, tcap_queue and tcap_back.
//
//   channel   direction  handshake       payload
//   in_i      sink       valid / ready   tcap_pkg::in_item_t  (one control tick)
//   out_o     source     valid / ready   tcap_pkg::out_item_t (one result per tick)
//   cfg_*     input      cfg_we_i only   cfg_idx_i, cfg_data_i (no read-back)
//
// Each tick passes through four steps in the back sequencer (product and difference, split
// partial products, recombine and clamp, level and handle update); that sequencer starts
// the next tick only as it finishes the current one, and so sets the sustained rate.
// Reset clears configuration to defaults and all handle state to zero; no clearing pass.
// The queue keeps the front accepting while the back works; the output register
// holds a finished transaction and stalls only the final step while it waits.
module traction_current_autopilot_core #(
  parameter int unsigned QUEUE_DEPTH = tcap_pkg::QueueDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  tcap_in_if.sink                       in_i,
  tcap_out_if.source                    out_o,
  input  logic                          cfg_we_i,
  input  logic [tcap_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tcap_pkg::CfgDataW-1:0] cfg_data_i
);

  tcap_pkg::cfg_t  cfg_q;
  tcap_pkg::work_t front_work, head_work;
  logic            push, full, pop, head_valid;

  // Configuration registers; writes beyond the list drop silently
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.current_max   <= tcap_pkg::CurrentMaxRst;
      cfg_q.speed_gain    <= tcap_pkg::SpeedGainRst;
      cfg_q.slip_gain     <= tcap_pkg::SlipGainRst;
      cfg_q.regen_disable <= tcap_pkg::RegenDisRst;
      cfg_q.level_scale   <= tcap_pkg::LevelScaleRst;
      cfg_q.holdoff_ticks <= tcap_pkg::HoldoffTicksRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tcap_pkg::RegCurrentMax:  cfg_q.current_max   <= cfg_data_i[14:0];
        tcap_pkg::RegSpeedGain:   cfg_q.speed_gain    <= cfg_data_i;
        tcap_pkg::RegSlipGain:    cfg_q.slip_gain     <= cfg_data_i;
        tcap_pkg::RegRegenDis:    cfg_q.regen_disable <= cfg_data_i[0];
        tcap_pkg::RegLevelScale:  cfg_q.level_scale   <= cfg_data_i;
        tcap_pkg::RegHoldoffTick: cfg_q.holdoff_ticks <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Classify incoming ticks: speed error, positive slip, lock conditions
  tcap_front u_front (
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .work_o (front_work)
  );

  // Decouple the front from the back sequencer
  tcap_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (front_work),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_data_o  (head_work)
  );

  // Carry out the arithmetic and the handle state update
  tcap_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_valid_i (head_valid),
    .head_data_i  (head_work),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule

[rtl/core/tcap_front.sv]
// Front end: accepts ticks from the input channel and classifies them into work items.
// Depends on tcap_pkg and tcap_in_if.
module tcap_front (
  tcap_in_if.sink          in_i,
  input  logic             full_i,
  output logic             push_o,
  output tcap_pkg::work_t  work_o
);

  logic signed [12:0] err;
  logic [12:0]        slip_raw;

  assign in_i.ready = ~full_i;
  assign push_o     = in_i.valid & ~full_i;

  always_comb begin
    err      = $signed({1'b0, in_i.data.speed_target}) - $signed({1'b0, in_i.data.speed_train});
    slip_raw = {1'b0, in_i.data.speed_wheel} - {1'b0, in_i.data.speed_train};

    work_o.err       = err;
    // negative slip counts as none
    work_o.slip      = slip_raw[12] ? 12'd0 : slip_raw[11:0];
    work_o.lock_set  = in_i.data.cylinder_pressure > tcap_pkg::PressureLimit;
    work_o.err_small = err < tcap_pkg::LockErrBand;
    work_o.motion    = in_i.data.motion_allowed;
    work_o.at_zero   = in_i.data.handle_at_zero;
    work_o.trac_on   = in_i.data.traction_active;
    work_o.brake_on  = in_i.data.braking_active;
  end

endmodule

[rtl/core/tcap_queue.sv]
// Short FIFO of classified work items between the front and the back.
// Depends on tcap_pkg for the work item type.
module tcap_queue #(
  parameter int unsigned Depth = tcap_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  tcap_pkg::work_t  push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             head_valid_o,
  output tcap_pkg::work_t  head_data_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr  = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  tcap_pkg::work_t entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o       = count_q == DepthCnt;
  assign head_valid_o = count_q != '0;
  assign head_data_o  = entry_q[rd_ptr_q];
  assign do_push      = push_i & ~full_o;
  assign do_pop       = pop_i & head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthCnt)
    else $error("queue fill count exceeds depth");

  a_pop_moves_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_pop && !do_push) |=> count_q == $past(count_q) - 1'b1)
    else $error("queue pop did not drain an entry");

endmodule

[rtl/core/tcap_back.sv]
// Back end: four-step sequencer computing current reference, relay, level and handle state.
// Depends on tcap_pkg and tcap_out_if.
module tcap_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tcap_pkg::cfg_t   cfg_i,
  input  logic             head_valid_i,
  input  tcap_pkg::work_t  head_data_i,
  output logic             pop_o,
  tcap_out_if.source       out_o
);

  localparam logic [1:0] StepMix  = 2'd0;
  localparam logic [1:0] StepPart = 2'd1;
  localparam logic [1:0] StepRef  = 2'd2;
  localparam logic [1:0] StepOut  = 2'd3;

  // Control
  logic       busy_q;
  logic [1:0] step_q;
  logic       out_valid_q;
  logic       out_free, done;

  // Datapath registers
  tcap_pkg::work_t      work_q;
  logic signed [30:0]   mix_q;
  logic [30:0]          part_lo_q;
  logic signed [30:0]   part_hi_q;
  logic signed [15:0]   iref_q;
  tcap_pkg::out_item_t  out_data_q;

  // Handle state
  logic signed [1:0]  relay_prev_q, relay_prev_d;
  logic signed [1:0]  mode_q, mode_d;
  logic signed [15:0] level_q, level_d;
  logic               lock_q, lock_d;
  logic               run_q, run_d;
  logic [15:0]        count_q, count_d;

  // Step arithmetic
  logic signed [29:0] prod_err;
  logic [27:0]        prod_slip;
  logic signed [30:0] mix_d;
  logic [30:0]        part_lo_d;
  logic signed [30:0] part_hi_d;
  logic signed [46:0] prod_full;
  logic signed [34:0] iref_wide, imax_wide, lo_wide, iref_clamp;
  logic signed [32:0] lvl_prod;
  logic signed [31:0] lvl_wide;
  logic signed [15:0] lvl_sat;
  logic signed [1:0]  want;
  logic [15:0]        count_tick;
  logic               run_tick;
  logic               reversal;

  assign out_free    = ~out_valid_q | out_o.ready;
  assign done        = busy_q & (step_q == StepOut) & out_free;
  assign pop_o       = head_valid_i & (~busy_q | done);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  always_comb begin
    prod_err  = $signed({1'b0, cfg_i.speed_gain}) * work_q.err;
    prod_slip = cfg_i.slip_gain * work_q.slip;
    mix_d     = $signed({prod_err[29], prod_err}) - $signed({3'b000, prod_slip});

    // current_max * mix split on bit 16 of mix
    part_lo_d = cfg_i.current_max * mix_q[15:0];
    part_hi_d = $signed({1'b0, cfg_i.current_max}) * $signed(mix_q[30:16]);

    prod_full  = $signed({part_hi_q, 16'h0000}) + $signed({16'h0000, part_lo_q});
    iref_wide  = $signed(prod_full[46:12]);
    imax_wide  = $signed({20'd0, cfg_i.current_max});
    lo_wide    = cfg_i.regen_disable ? 35'sd0 : -imax_wide;
    iref_clamp = iref_wide;
    if (iref_wide > imax_wide) begin
      iref_clamp = imax_wide;
    end else if (iref_wide < lo_wide) begin
      iref_clamp = lo_wide;
    end
  end

  always_comb begin
    if (iref_q > tcap_pkg::RelayBand) begin
      want = tcap_pkg::ModeTraction;
    end else if (iref_q < -tcap_pkg::RelayBand) begin
      want = tcap_pkg::ModeBrake;
    end else begin
      want = tcap_pkg::ModeNeutral;
    end

    lvl_prod = iref_q * $signed({1'b0, cfg_i.level_scale});
    lvl_wide = lvl_prod[32:1];
    if (lvl_wide > 32'sd32767) begin
      lvl_sat = 16'sh7FFF;
    end else if (lvl_wide < -32'sd32768) begin
      lvl_sat = -16'sh8000;
    end else begin
      lvl_sat = lvl_wide[15:0];
    end

    // advance the hold-off timer at the start of the tick
    count_tick = count_q;
    if (run_q && count_q != tcap_pkg::CountMax) begin
      count_tick = count_q + 16'd1;
    end
    run_tick = run_q & ~(count_tick >= cfg_i.holdoff_ticks);

    reversal = (want != tcap_pkg::ModeNeutral) && (relay_prev_q != tcap_pkg::ModeNeutral) &&
               (want != relay_prev_q);

    relay_prev_d = want;
    mode_d       = mode_q;
    level_d      = level_q;
    run_d        = run_tick;
    count_d      = count_tick;
    if (!run_tick) begin
      if (!work_q.motion || (reversal && !work_q.at_zero)) begin
        mode_d  = tcap_pkg::ModeNeutral;
        run_d   = 1'b1;
        count_d = '0;
      end else if (want == tcap_pkg::ModeTraction && !work_q.trac_on) begin
        mode_d  = work_q.at_zero ? tcap_pkg::ModeTraction : tcap_pkg::ModeNeutral;
        run_d   = 1'b1;
        count_d = '0;
      end else if (want == tcap_pkg::ModeBrake && !work_q.brake_on) begin
        mode_d  = work_q.at_zero ? tcap_pkg::ModeBrake : tcap_pkg::ModeNeutral;
        run_d   = 1'b1;
        count_d = '0;
      end else if (lvl_sat > 16'sd0 && lock_q) begin
        // the lock from the previous tick zeroes a positive level
        level_d = 16'sd0;
      end else begin
        level_d = lvl_sat;
      end
    end

    lock_d = work_q.lock_set | (lock_q & work_q.err_small);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      step_q       <= StepMix;
      out_valid_q  <= 1'b0;
      relay_prev_q <= tcap_pkg::ModeNeutral;
      mode_q       <= tcap_pkg::ModeNeutral;
      level_q      <= '0;
      lock_q       <= 1'b0;
      run_q        <= 1'b0;
      count_q      <= '0;
    end else begin
      if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (pop_o) begin
        busy_q <= 1'b1;
        step_q <= StepMix;
      end else if (done) begin
        busy_q <= 1'b0;
      end else if (busy_q && step_q != StepOut) begin
        step_q <= step_q + 2'd1;
      end
      if (done) begin
        out_valid_q  <= 1'b1;
        relay_prev_q <= relay_prev_d;
        mode_q       <= mode_d;
        level_q      <= level_d;
        lock_q       <= lock_d;
        run_q        <= run_d;
        count_q      <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      work_q <= head_data_i;
    end
    if (busy_q && step_q == StepMix) begin
      mix_q <= mix_d;
    end
    if (busy_q && step_q == StepPart) begin
      part_lo_q <= part_lo_d;
      part_hi_q <= part_hi_d;
    end
    if (busy_q && step_q == StepRef) begin
      iref_q <= iref_clamp[15:0];
    end
    if (done) begin
      out_data_q.drive_mode      <= mode_d;
      out_data_q.drive_level     <= level_d;
      out_data_q.traction_locked <= lock_d;
      out_data_q.holdoff_busy    <= run_d;
    end
  end

  a_step_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && step_q != StepOut && !pop_o) |=> busy_q && step_q == $past(step_q) + 2'd1)
    else $error("sequencer skipped or stalled a step");

  a_iref_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && step_q == StepOut) |->
      (iref_q <= $signed({1'b0, cfg_i.current_max}) &&
       iref_q >= -$signed({1'b0, cfg_i.current_max})))
    else $error("current reference outside clamp");

  a_regen_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && step_q == StepOut && cfg_i.regen_disable) |-> !iref_q[15])
    else $error("negative current reference with regeneration disabled");

  a_done_presents: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> out_valid_q)
    else $error("finished transaction not presented");

endmodule

[sim/tb.sv]
// Self-checking testbench for traction_current_autopilot_core: directed ticks, then random
// phases under several register settings and handshake pressure. Depends on tcap_pkg,
// tcap_in_if, tcap_out_if and the core RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QuietLimit   = 4000;
  localparam int unsigned PhaseTicks   = 60;
  localparam int unsigned RandomPhases = 8;
  localparam int unsigned SettleCycles = 16;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [tcap_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [tcap_pkg::CfgDataW-1:0] cfg_data_i;

  tcap_in_if  in_if ();
  tcap_out_if out_if ();

  traction_current_autopilot_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Ticks waiting to be sent, results owed by the core
  tcap_pkg::in_item_t  tick_queue [$];
  tcap_pkg::out_item_t due_results [$];

  // Handshake pressure, in percent of cycles
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  int unsigned         fails;
  int unsigned         quiet_cycles;
  tcap_pkg::out_item_t want_r;
  tcap_pkg::out_item_t got_r;

  // Shadow of the autopilot: register file and handle state
  tcap_pkg::cfg_t     shadow_cfg;
  logic signed [1:0]  relay_last;
  logic signed [1:0]  mode_cmd;
  logic signed [15:0] level_cmd;
  logic               lock_on;
  logic               hold_run;
  logic [15:0]        hold_cnt;

  // Advance the shadow by one control tick and return the result it owes.
  function automatic tcap_pkg::out_item_t predict_tick(input tcap_pkg::in_item_t it);
    longint              err;
    longint              slip;
    longint              mix;
    longint              iref;
    longint              floor_i;
    longint              lvl;
    logic signed [1:0]   want;
    logic signed [1:0]   prev;
    logic                reversal;
    tcap_pkg::out_item_t r;

    // The timer advances first, so a start on this tick is seen next tick
    if (hold_run) begin
      if (hold_cnt != tcap_pkg::CountMax) hold_cnt = hold_cnt + 16'd1;
      if (hold_cnt >= shadow_cfg.holdoff_ticks) hold_run = 1'b0;
    end

    err  = longint'(it.speed_target) - longint'(it.speed_train);
    slip = longint'(it.speed_wheel) - longint'(it.speed_train);
    if (slip < 0) slip = 0;
    mix  = longint'(shadow_cfg.speed_gain) * err - longint'(shadow_cfg.slip_gain) * slip;
    // Arithmetic shift on a signed value rounds toward minus infinity
    iref = (longint'(shadow_cfg.current_max) * mix) >>> 12;
    floor_i = shadow_cfg.regen_disable ? 0 : -longint'(shadow_cfg.current_max);
    if (iref > longint'(shadow_cfg.current_max)) iref = longint'(shadow_cfg.current_max);
    if (iref < floor_i) iref = floor_i;

    if (iref > longint'(tcap_pkg::RelayBand)) want = tcap_pkg::ModeTraction;
    else if (iref < -longint'(tcap_pkg::RelayBand)) want = tcap_pkg::ModeBrake;
    else want = tcap_pkg::ModeNeutral;
    prev       = relay_last;
    relay_last = want;
    reversal   = (want == tcap_pkg::ModeTraction && prev == tcap_pkg::ModeBrake) ||
                 (want == tcap_pkg::ModeBrake && prev == tcap_pkg::ModeTraction);

    lvl = (iref * longint'(shadow_cfg.level_scale)) >>> 1;
    if (lvl > 32767) lvl = 32767;
    if (lvl < -32768) lvl = -32768;

    // Handle logic runs only with the timer stopped; the lock used here is last tick's
    if (!hold_run) begin
      if (!it.motion_allowed || (reversal && !it.handle_at_zero)) begin
        mode_cmd = tcap_pkg::ModeNeutral;
        hold_run = 1'b1;
        hold_cnt = '0;
      end else if (want == tcap_pkg::ModeTraction && !it.traction_active) begin
        mode_cmd = it.handle_at_zero ? tcap_pkg::ModeTraction : tcap_pkg::ModeNeutral;
        hold_run = 1'b1;
        hold_cnt = '0;
      end else if (want == tcap_pkg::ModeBrake && !it.braking_active) begin
        mode_cmd = it.handle_at_zero ? tcap_pkg::ModeBrake : tcap_pkg::ModeNeutral;
        hold_run = 1'b1;
        hold_cnt = '0;
      end else if (lvl > 0 && lock_on) begin
        level_cmd = '0;
      end else begin
        level_cmd = lvl[15:0];
      end
    end

    // Pressure sets the lock; otherwise it holds only while the speed error stays below the band
    if (it.cylinder_pressure > tcap_pkg::PressureLimit) lock_on = 1'b1;
    else lock_on = lock_on && (err < longint'(tcap_pkg::LockErrBand));

    r.drive_mode      = mode_cmd;
    r.drive_level     = level_cmd;
    r.traction_locked = lock_on;
    r.holdoff_busy    = hold_run;
    return r;
  endfunction

  function automatic tcap_pkg::in_item_t mk(input int tgt, input int trn, input int whl,
                                            input int prs, input logic [3:0] flags);
    tcap_pkg::in_item_t r;
    r.speed_target      = tgt[11:0];
    r.speed_train       = trn[11:0];
    r.speed_wheel       = whl[11:0];
    r.cylinder_pressure = prs[9:0];
    {r.motion_allowed, r.handle_at_zero, r.traction_active, r.braking_active} = flags;
    return r;
  endfunction

  // Pick a speed within a dozen km/h of the given one
  function automatic logic [11:0] near(input logic [11:0] base);
    int v;
    v = int'(base) + int'($urandom_range(240)) - 120;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[11:0];
  endfunction

  task automatic write_reg(input logic [tcap_pkg::CfgIdxW-1:0] idx,
                           input logic [tcap_pkg::CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
  endtask

  // Write the whole register file back to back; call only with the core idle.
  task automatic apply_cfg(input tcap_pkg::cfg_t c);
    write_reg(tcap_pkg::RegCurrentMax, {1'b0, c.current_max});
    write_reg(tcap_pkg::RegSpeedGain, c.speed_gain);
    write_reg(tcap_pkg::RegSlipGain, c.slip_gain);
    write_reg(tcap_pkg::RegRegenDis, {15'd0, c.regen_disable});
    write_reg(tcap_pkg::RegLevelScale, c.level_scale);
    write_reg(tcap_pkg::RegHoldoffTick, c.holdoff_ticks);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    shadow_cfg = c;
  endtask

  // Hold until every tick is sent and answered, then let the pipeline settle.
  // Sample at the falling edge so every transaction of the rising edge is counted.
  task automatic drain();
    @(negedge clk_i);
    while (tick_queue.size() != 0 || in_if.valid || due_results.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Driver: advance to the next pending tick once the current transaction is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.data  <= '0;
    end else if (!in_if.valid || in_if.ready) begin
      if (tick_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_if.valid <= 1'b1;
        in_if.data  <= tick_queue.pop_front();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: stall at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: predict on every accepted tick, check every accepted result, watch for hangs
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) due_results.push_back(predict_tick(in_if.data));
      if (out_if.valid && out_if.ready) begin
        got_r = out_if.data;
        if (due_results.size() == 0) begin
          $error("result with no tick outstanding: mode %0d level %0d",
                 got_r.drive_mode, got_r.drive_level);
          fails++;
        end else begin
          want_r = due_results.pop_front();
          if (got_r.drive_mode !== want_r.drive_mode) begin
            $error("drive_mode: expected %0d, actual %0d", want_r.drive_mode, got_r.drive_mode);
            fails++;
          end
          if (got_r.drive_level !== want_r.drive_level) begin
            $error("drive_level: expected %0d, actual %0d",
                   want_r.drive_level, got_r.drive_level);
            fails++;
          end
          if (got_r.traction_locked !== want_r.traction_locked) begin
            $error("traction_locked: expected %0b, actual %0b",
                   want_r.traction_locked, got_r.traction_locked);
            fails++;
          end
          if (got_r.holdoff_busy !== want_r.holdoff_busy) begin
            $error("holdoff_busy: expected %0b, actual %0b",
                   want_r.holdoff_busy, got_r.holdoff_busy);
            fails++;
          end
        end
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    tcap_pkg::cfg_t     c;
    tcap_pkg::in_item_t it;

    // Drive every input known from time zero; hold reset
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_data_i     = '0;
    in_if.valid    = 1'b0;
    in_if.data     = '0;
    out_if.ready   = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    fails          = 0;
    quiet_cycles   = 0;

    shadow_cfg = '{current_max: tcap_pkg::CurrentMaxRst, speed_gain: tcap_pkg::SpeedGainRst,
                   slip_gain: tcap_pkg::SlipGainRst, regen_disable: tcap_pkg::RegenDisRst,
                   level_scale: tcap_pkg::LevelScaleRst,
                   holdoff_ticks: tcap_pkg::HoldoffTicksRst};
    relay_last = tcap_pkg::ModeNeutral;
    mode_cmd   = tcap_pkg::ModeNeutral;
    level_cmd  = '0;
    lock_on    = 1'b0;
    hold_run   = 1'b0;
    hold_cnt   = '0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed, reset settings. Flags are {motion, at_zero, traction, braking}.
    tick_queue.push_back(mk(0, 0, 0, 0, 4'b1111));             // all zero
    tick_queue.push_back(mk(4095, 0, 0, 1023, 4'b1111));       // full traction, lock set
    tick_queue.push_back(mk(2000, 1000, 0, 0, 4'b1111));       // late lock zeroes level
    tick_queue.push_back(mk(1000, 1000, 0, 41, 4'b1111));      // pressure just over limit
    tick_queue.push_back(mk(1020, 1000, 0, 40, 4'b1111));      // lock kept inside band
    tick_queue.push_back(mk(1000, 1010, 4095, 0, 4'b1111));    // slip drives full brake
    tick_queue.push_back(mk(4095, 0, 0, 0, 4'b1011));          // reversal off zero
    tick_queue.push_back(mk(4095, 0, 4095, 1023, 4'b0000));    // frozen by hold-off
    drain();

    // Directed, unity current gain so the relay band edges are reachable
    c = '{current_max: 15'd64, speed_gain: 16'd64, slip_gain: 16'd64, regen_disable: 1'b0,
          level_scale: tcap_pkg::LevelScaleRst, holdoff_ticks: 16'd0};
    apply_cfg(c);
    tick_queue.push_back(mk(1050, 1000, 0, 0, 4'b1111));       // on the upper band edge
    tick_queue.push_back(mk(1051, 1000, 0, 0, 4'b1111));       // just past it
    tick_queue.push_back(mk(950, 1000, 0, 0, 4'b1111));        // on the lower band edge
    tick_queue.push_back(mk(949, 1000, 0, 0, 4'b1111));        // just past it
    tick_queue.push_back(mk(1051, 1000, 0, 0, 4'b1011));       // reversal off zero
    tick_queue.push_back(mk(1060, 1000, 0, 0, 4'b1101));       // traction off, at zero
    tick_queue.push_back(mk(1060, 1000, 0, 0, 4'b1001));       // traction off, not at zero
    tick_queue.push_back(mk(940, 1000, 0, 0, 4'b1110));        // braking off, at zero
    tick_queue.push_back(mk(940, 1000, 0, 0, 4'b1010));        // braking off, not at zero
    tick_queue.push_back(mk(1060, 1000, 0, 0, 4'b0111));       // motion withdrawn
    tick_queue.push_back(mk(1100, 1000, 1080, 0, 4'b1111));    // partial slip
    tick_queue.push_back(mk(1100, 1000, 900, 0, 4'b1111));     // wheel slower than train
    drain();

    // Random phases: extremes first, then random settings with small hold-off
    for (int p = 0; p < RandomPhases; p++) begin
      case (p)
        0: c = '{current_max: 15'd20000, speed_gain: 16'hFFFF, slip_gain: 16'hFFFF,
                 regen_disable: 1'b0, level_scale: 16'hFFFF, holdoff_ticks: 16'd0};
        1: c = '{current_max: 15'd0, speed_gain: 16'd0, slip_gain: 16'd0,
                 regen_disable: 1'b1, level_scale: 16'd0, holdoff_ticks: 16'hFFFF};
        default: begin
          c.current_max   = 15'($urandom_range(20000));
          c.speed_gain    = 16'($urandom_range(65535));
          c.slip_gain     = 16'($urandom_range(65535));
          c.regen_disable = 1'($urandom_range(1));
          c.level_scale   = 16'($urandom_range(65535));
          c.holdoff_ticks = 16'($urandom_range(4));
        end
      endcase
      apply_cfg(c);

      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase

      // Mostly plausible ticks: speeds near each other, flags mostly permissive
      for (int n = 0; n < PhaseTicks; n++) begin
        it.speed_train       = 12'($urandom_range(4095));
        it.speed_target      = $urandom_range(1) ? 12'($urandom_range(4095)) :
                                                   near(it.speed_train);
        it.speed_wheel       = ($urandom_range(3) == 0) ? 12'($urandom_range(4095)) :
                                                          near(it.speed_train);
        it.cylinder_pressure = $urandom_range(1) ? 10'($urandom_range(1023)) :
                                                   10'($urandom_range(60));
        it.motion_allowed    = ($urandom_range(99) < 92);
        it.handle_at_zero    = ($urandom_range(99) < 70);
        it.traction_active   = ($urandom_range(99) < 80);
        it.braking_active    = ($urandom_range(99) < 80);
        tick_queue.push_back(it);
      end
      drain();
    end

    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
